FILE: sv/atq_pkg.sv
package atq_pkg;

   localparam int ALARM_FIELD_W   = 16;
   localparam int TRIGGER_FIELD_W = 4;
   localparam int MAX_TRIGGERS    = 4;
   localparam int HOLD_W          = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd10;
   localparam logic [HOLD_W-1:0] HOLD_ONE         = 16'h0001;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MASK0    = 3'd0,
      REG_MASK1    = 3'd1,
      REG_MASK2    = 3'd2,
      REG_MASK3    = 3'd3,
      REG_AND_MODE = 3'd4,
      REG_HOLD     = 3'd5
   } reg_index_type;

   // per-trigger control for one tick
   typedef struct packed {
      logic step;
      logic hit;
   } trig_ctl_type;

endpackage

FILE: sv/atq_if.sv
interface atq_req_if;
   logic                               valid;
   logic                               ready;
   logic [atq_pkg::ALARM_FIELD_W-1:0]  alarm_bits;

   modport source (output valid, output alarm_bits, input ready);
   modport sink   (input valid, input alarm_bits, output ready);
endinterface

interface atq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [atq_pkg::TRIGGER_FIELD_W-1:0] trigger_bits;

   modport source (output valid, output trigger_bits, input ready);
   modport sink   (input valid, input trigger_bits, output ready);
endinterface

interface atq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [atq_pkg::CSR_INDEX_W-1:0] index;
   logic [atq_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/atq_trigger.sv
module atq_trigger (
   input  logic                         clock,
   input  logic                         reset,
   input  atq_pkg::trig_ctl_type        ctl,
   input  logic [atq_pkg::HOLD_W-1:0]   hold_ticks,
   output logic                         active
);

   typedef enum logic [1:0] {
      PH_OFF,
      PH_CONFIRM,
      PH_ON,
      PH_HOLD
   } phase_type;

   phase_type                    phase_ff;
   logic [atq_pkg::HOLD_W-1:0]   hold_count_ff;
   logic [atq_pkg::HOLD_W-1:0]   hold_dec;

   assign hold_dec = hold_count_ff - atq_pkg::HOLD_ONE;
   assign active   = (phase_ff == PH_ON) || (phase_ff == PH_HOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OFF;
         hold_count_ff <= '0;
      end else if (ctl.step) begin
         unique case (phase_ff)
            PH_OFF: begin
               phase_ff <= ctl.hit ? PH_CONFIRM : PH_OFF;
            end
            PH_CONFIRM: begin
               phase_ff <= ctl.hit ? PH_ON : PH_OFF;
            end
            PH_ON: begin
               hold_count_ff <= hold_ticks;
               phase_ff      <= ctl.hit ? PH_ON : PH_HOLD;
            end
            PH_HOLD: begin
               hold_count_ff <= hold_dec;
               if (hold_dec == '0) begin
                  phase_ff <= PH_OFF;
               end else begin
                  phase_ff <= ctl.hit ? PH_ON : PH_HOLD;
               end
            end
            default: begin
               phase_ff <= PH_OFF;
            end
         endcase
      end
   end

endmodule

FILE: sv/alarm_trigger_qualifier.sv
// Alarm trigger qualifier.
// req_chan: one item per tick carrying the alarm vector (alarm_bits).
// rsp_chan: one item per accepted req item, trigger_bits holding bit t set
//   when trigger t was on or holding at the start of that tick.
// csr_chan: register writes (masks 0..3, AND-mode bits, hold length);
//   always ready, meant to be written while no items are in flight.
//   Unknown indexes are dropped.
// The result is registered in the output register, or in the skid register.
// Throughput: one item per cycle while the skid is empty; the trigger state
//   machines update on acceptance; the result sits in an output register.
// A skid register behind the output register keeps req_chan ready for one
//   more item while rsp_chan stalls; req_chan.ready drops only when both
//   hold an undelivered result.
// Reset: all triggers off, hold counts zero, masks and AND-mode bits zero,
//   hold length 10, output and skid registers empty.
// Triggers at or above TRIGGER_COUNT always report zero; alarm bits at or
//   above ALARM_WIDTH are ignored.
module alarm_trigger_qualifier #(
   parameter int TRIGGER_COUNT = 4,
   parameter int ALARM_WIDTH   = 16
) (
   input  logic       clock,
   input  logic       reset,
   atq_req_if.sink    req_chan,
   atq_rsp_if.source  rsp_chan,
   atq_csr_if.sink    csr_chan
);

   localparam int USED_W = (ALARM_WIDTH < atq_pkg::ALARM_FIELD_W) ?
                           ALARM_WIDTH : atq_pkg::ALARM_FIELD_W;
   localparam int TF_W   = atq_pkg::TRIGGER_FIELD_W;

   logic [USED_W-1:0]          mask_ff [TRIGGER_COUNT];
   logic [TRIGGER_COUNT-1:0]   and_mode_ff;
   logic [atq_pkg::HOLD_W-1:0] hold_ticks_ff;

   logic [TF_W-1:0] out_bits_ff, out_bits_in;
   logic            out_valid_ff, out_valid_in;
   logic [TF_W-1:0] skid_bits_ff, skid_bits_in;
   logic            skid_valid_ff, skid_valid_in;

   logic              accept;
   logic              deliver;
   logic [USED_W-1:0] alarms;
   logic [TF_W-1:0]   active;

   assign accept  = req_chan.valid && req_chan.ready;
   assign deliver = out_valid_ff && rsp_chan.ready;
   assign alarms  = req_chan.alarm_bits[USED_W-1:0];

   assign req_chan.ready     = !skid_valid_ff;
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.trigger_bits = out_bits_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TRIGGER_COUNT; t++) begin
            mask_ff[t] <= '0;
         end
         and_mode_ff   <= '0;
         hold_ticks_ff <= atq_pkg::HOLD_TICKS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index) inside
            atq_pkg::REG_MASK0, atq_pkg::REG_MASK1,
            atq_pkg::REG_MASK2, atq_pkg::REG_MASK3: begin
               for (int t = 0; t < TRIGGER_COUNT; t++) begin
                  if (csr_chan.index[1:0] == 2'(t)) begin
                     mask_ff[t] <= csr_chan.data[USED_W-1:0];
                  end
               end
            end
            atq_pkg::REG_AND_MODE: begin
               and_mode_ff <= csr_chan.data[TRIGGER_COUNT-1:0];
            end
            atq_pkg::REG_HOLD: begin
               hold_ticks_ff <= csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   // trigger state machines
   for (genvar t = 0; t < TF_W; t++) begin : g_trig
      if (t < TRIGGER_COUNT) begin : g_used
         atq_pkg::trig_ctl_type ctl;
         logic [USED_W-1:0]     hit_bits;

         assign hit_bits = alarms & mask_ff[t];
         assign ctl.step = accept;
         assign ctl.hit  = (mask_ff[t] != '0) && (alarms != '0) &&
                           (and_mode_ff[t] ? (hit_bits == mask_ff[t])
                                           : (hit_bits != '0));

         atq_trigger u_trigger (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .hold_ticks (hold_ticks_ff),
            .active     (active[t])
         );
      end else begin : g_unused
         assign active[t] = 1'b0;
      end
   end

   // output register with skid
   always_comb begin
      out_bits_in   = out_bits_ff;
      out_valid_in  = out_valid_ff;
      skid_bits_in  = skid_bits_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (deliver) begin
            out_bits_in   = skid_bits_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || deliver) begin
            out_bits_in  = active;
            out_valid_in = 1'b1;
         end else begin
            skid_bits_in  = active;
            skid_valid_in = 1'b1;
         end
      end else if (deliver) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_bits_ff  <= out_bits_in;
      skid_bits_ff <= skid_bits_in;
   end

`ifndef SYNTHESIS
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !rsp_chan.ready) |=> skid_valid_ff)
      else $error("item taken during stall was not parked in skid");

   a_accept_yields_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted item produced no result");

   a_unused_bits_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_bits_ff >> TRIGGER_COUNT) == '0))
      else $error("result reports a trigger beyond TRIGGER_COUNT");
`endif

endmodule
